// File: rtl/core/tdu_pkg.sv
package tdu_pkg;

    localparam int DATA_BITS_DEF = 8;
    localparam logic [7:0] RELOAD_RESET = 8'd176;
    localparam logic [8:0] TIMER_SPAN = 9'd256;
    localparam logic [7:0] TIMER_TOP = 8'hFF;

    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_TX   = 2'd1,
        MODE_RX   = 2'd2
    } t_mode;

    typedef struct packed {
        logic       tx_line;
        logic       tx_done;
        logic       rx_done;
        logic [7:0] rx_data;
        logic       timer_running;
    } t_result;

endpackage

// File: rtl/core/tdu_if.sv
interface tdu_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] tx_data;
    logic       rx_line;

    modport source (output valid, output mode, output tx_data, output rx_line, input ready);
    modport sink (input valid, input mode, input tx_data, input rx_line, output ready);
endinterface

interface tdu_out_if;
    logic       valid;
    logic       ready;
    logic       tx_line;
    logic       tx_done;
    logic       rx_done;
    logic [7:0] rx_data;
    logic       timer_running;

    modport source (output valid, output tx_line, output tx_done, output rx_done,
                    output rx_data, output timer_running, input ready);
    modport sink (input valid, input tx_line, input tx_done, input rx_done,
                  input rx_data, input timer_running, output ready);
endinterface

interface tdu_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/timer_driven_uart_txrx.sv
// Output: each result is registered and appears on the output in the cycle after its
// item is accepted. Throughput: one item per cycle while the output is ready; the single
// output register is refilled in the cycle its result is taken.
// Reset: synchronous, active low; timer stopped, tx line idle high, flags and shift
// registers cleared, reload value 176.
module timer_driven_uart_txrx #(
    parameter int DATA_BITS = tdu_pkg::DATA_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tdu_in_if.sink    i_in,
    tdu_out_if.source o_out,
    tdu_cfg_if.sink   i_cfg
);

    logic             step_en;
    logic             in_ready;
    tdu_pkg::t_result next_result;
    tdu_pkg::t_result out_result;

    assign i_in.ready  = in_ready;
    assign step_en     = i_in.valid && in_ready;
    assign i_cfg.ready = 1'b1;

    tdu_core #(
        .DATA_BITS (DATA_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step_en  (step_en),
        .i_mode     (i_in.mode),
        .i_tx_data  (i_in.tx_data),
        .i_rx_line  (i_in.rx_line),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (i_cfg.data),
        .o_next     (next_result)
    );

    tdu_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step_en),
        .i_result    (next_result),
        .i_out_ready (o_out.ready),
        .o_valid     (o_out.valid),
        .o_result    (out_result),
        .o_in_ready  (in_ready)
    );

    assign o_out.tx_line       = out_result.tx_line;
    assign o_out.tx_done       = out_result.tx_done;
    assign o_out.rx_done       = out_result.rx_done;
    assign o_out.rx_data       = out_result.rx_data;
    assign o_out.timer_running = out_result.timer_running;

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> o_out.valid)
        else $error("accepted item produced no result");

    a_tx_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && i_in.mode == tdu_pkg::MODE_TX
        |=> !o_out.tx_line && !o_out.tx_done && o_out.timer_running)
        else $error("start transmit did not drive start bit");

    a_rx_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && i_in.mode == tdu_pkg::MODE_RX
        |=> !o_out.rx_done && o_out.timer_running)
        else $error("start receive did not arm timer");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled with empty output register");

endmodule

// File: rtl/core/tdu_core.sv
module tdu_core #(
    parameter int DATA_BITS = tdu_pkg::DATA_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step_en,
    input  logic [1:0]        i_mode,
    input  logic [7:0]        i_tx_data,
    input  logic              i_rx_line,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data,
    output tdu_pkg::t_result  o_next
);

    localparam logic [3:0] LAST_BIT = 4'(DATA_BITS);
    localparam logic [3:0] STOP_BIT = 4'(DATA_BITS + 1);

    logic [7:0] r_reload;
    logic [7:0] r_tick, n_tick;
    logic [3:0] r_bit, n_bit;
    logic       r_sending, n_sending;
    logic [7:0] r_send_shift, n_send_shift;
    logic [7:0] r_recv_shift, n_recv_shift;
    logic       r_line, n_line;
    logic       r_send_fin, n_send_fin;
    logic       r_recv_fin, n_recv_fin;
    logic       r_running, n_running;
    logic [7:0] half;
    logic [3:0] bit_inc;

    assign half    = 8'((tdu_pkg::TIMER_SPAN - {1'b0, r_reload}) >> 1);
    assign bit_inc = r_bit + 4'd1;

    always_comb begin
        n_tick       = r_tick;
        n_bit        = r_bit;
        n_sending    = r_sending;
        n_send_shift = r_send_shift;
        n_recv_shift = r_recv_shift;
        n_line       = r_line;
        n_send_fin   = r_send_fin;
        n_recv_fin   = r_recv_fin;
        n_running    = r_running;
        case (i_mode)
            tdu_pkg::MODE_TX: begin
                n_send_shift = i_tx_data;
                n_tick       = r_reload;
                n_running    = 1'b1;
                n_line       = 1'b0;
                n_send_fin   = 1'b0;
                n_sending    = 1'b1;
            end
            tdu_pkg::MODE_RX: begin
                n_tick     = 8'(tdu_pkg::TIMER_SPAN - {1'b0, half});
                n_running  = 1'b1;
                n_recv_fin = 1'b0;
                n_sending  = 1'b0;
            end
            default: begin
                if (r_running) begin
                    if (r_tick == tdu_pkg::TIMER_TOP) begin
                        n_tick = r_reload;
                        if (r_sending) begin
                            n_bit = bit_inc;
                            if (bit_inc <= LAST_BIT) begin
                                n_line       = r_send_shift[0];
                                n_send_shift = r_send_shift >> 1;
                            end else if (bit_inc == STOP_BIT) begin
                                n_line = 1'b1;
                            end else begin
                                n_bit      = '0;
                                n_running  = 1'b0;
                                n_send_fin = 1'b1;
                            end
                        end else begin
                            if (r_bit == 4'd0) begin
                                if (!i_rx_line) begin
                                    n_recv_shift = '0;
                                    n_bit        = 4'd1;
                                end else begin
                                    n_running = 1'b0;
                                end
                            end else if (r_bit <= LAST_BIT) begin
                                n_recv_shift = {i_rx_line, r_recv_shift[7:1]};
                                n_bit        = bit_inc;
                            end else begin
                                n_bit     = '0;
                                n_running = 1'b0;
                                if (i_rx_line) begin
                                    n_recv_fin = 1'b1;
                                end
                            end
                        end
                    end else begin
                        n_tick = r_tick + 8'd1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload <= tdu_pkg::RELOAD_RESET;
        end else if (i_cfg_we) begin
            r_reload <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick       <= '0;
            r_bit        <= '0;
            r_sending    <= 1'b0;
            r_send_shift <= '0;
            r_recv_shift <= '0;
            r_line       <= 1'b1;
            r_send_fin   <= 1'b0;
            r_recv_fin   <= 1'b0;
            r_running    <= 1'b0;
        end else if (i_step_en) begin
            r_tick       <= n_tick;
            r_bit        <= n_bit;
            r_sending    <= n_sending;
            r_send_shift <= n_send_shift;
            r_recv_shift <= n_recv_shift;
            r_line       <= n_line;
            r_send_fin   <= n_send_fin;
            r_recv_fin   <= n_recv_fin;
            r_running    <= n_running;
        end
    end

    assign o_next.tx_line       = n_line;
    assign o_next.tx_done       = n_send_fin;
    assign o_next.rx_done       = n_recv_fin;
    assign o_next.rx_data       = n_recv_shift;
    assign o_next.timer_running = n_running;

endmodule

// File: rtl/core/tdu_out_stage.sv
module tdu_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  tdu_pkg::t_result  i_result,
    input  logic              i_out_ready,
    output logic              o_valid,
    output tdu_pkg::t_result  o_result,
    output logic              o_in_ready
);

    logic             r_valid;
    tdu_pkg::t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid    = r_valid;
    assign o_result   = r_result;
    assign o_in_ready = !r_valid || i_out_ready;

endmodule

// File: tb/sv/tb_timer_driven_uart_txrx.sv
`timescale 1ns / 1ps
module tb_timer_driven_uart_txrx;

    localparam int DATA_BITS = tdu_pkg::DATA_BITS_DEF;
    localparam int FRAME_BITS = DATA_BITS + 2;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD = 60;
    localparam int PHASE_ITEMS = 100;
    localparam int MAX_PRINTS = 50;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] tx_data;
        logic       rx_line;
    } t_tick;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tdu_in_if  in_if ();
    tdu_out_if out_if ();
    tdu_cfg_if cfg_if ();

    timer_driven_uart_txrx #(.DATA_BITS(DATA_BITS)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    logic [7:0] uart_reload;
    logic [7:0] uart_tick;
    logic [3:0] uart_bit;
    logic       uart_sending;
    logic [7:0] uart_tx_shift;
    logic [7:0] uart_rx_shift;
    logic       uart_line;
    logic       uart_tx_fin;
    logic       uart_rx_fin;
    logic       uart_run;

    t_tick            tick_queue[$];
    tdu_pkg::t_result expected_pins[$];
    t_tick            cur_tick;

    int  period = 80;
    int  n_queued = 0;
    int  n_taken = 0;
    int  n_checked = 0;
    int  n_errors = 0;
    int  n_frames = 0;
    int  n_reload_writes = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_left = 0;
    int  idle_count = 0;
    bit  quiet = 1'b0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;
    bit  tick_taken = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic uart_reset();
        uart_reload   = tdu_pkg::RELOAD_RESET;
        uart_tick     = 8'd0;
        uart_bit      = 4'd0;
        uart_sending  = 1'b0;
        uart_tx_shift = 8'd0;
        uart_rx_shift = 8'd0;
        uart_line     = 1'b1;
        uart_tx_fin   = 1'b0;
        uart_rx_fin   = 1'b0;
        uart_run      = 1'b0;
    endtask

    task automatic tx_bit_step();
        uart_bit = uart_bit + 4'd1;
        if (uart_bit <= DATA_BITS) begin
            uart_line     = uart_tx_shift[0];
            uart_tx_shift = uart_tx_shift >> 1;
        end else if (uart_bit == DATA_BITS + 1) begin
            uart_line = 1'b1;
        end else begin
            uart_bit    = 4'd0;
            uart_run    = 1'b0;
            uart_tx_fin = 1'b1;
        end
    endtask

    task automatic rx_bit_step(input logic rx);
        if (uart_bit == 4'd0) begin
            if (!rx) begin
                uart_rx_shift = 8'd0;
                uart_bit      = 4'd1;
            end else begin
                uart_run = 1'b0;
            end
        end else if (uart_bit <= DATA_BITS) begin
            uart_rx_shift = {rx, uart_rx_shift[7:1]};
            uart_bit      = uart_bit + 4'd1;
        end else begin
            uart_bit = 4'd0;
            uart_run = 1'b0;
            if (rx) begin
                uart_rx_fin = 1'b1;
            end
        end
    endtask

    task automatic uart_advance(input t_tick t, output tdu_pkg::t_result r);
        logic [8:0] half;
        logic [8:0] preload;
        if (t.mode == tdu_pkg::MODE_TX) begin
            uart_tx_shift = t.tx_data;
            uart_tick     = uart_reload;
            uart_run      = 1'b1;
            uart_line     = 1'b0;
            uart_tx_fin   = 1'b0;
            uart_sending  = 1'b1;
        end else if (t.mode == tdu_pkg::MODE_RX) begin
            half         = (tdu_pkg::TIMER_SPAN - {1'b0, uart_reload}) >> 1;
            preload      = tdu_pkg::TIMER_SPAN - half;
            uart_tick    = preload[7:0];
            uart_run     = 1'b1;
            uart_rx_fin  = 1'b0;
            uart_sending = 1'b0;
        end else if (uart_run) begin
            if (uart_tick == tdu_pkg::TIMER_TOP) begin
                uart_tick = uart_reload;
                if (uart_sending) begin
                    tx_bit_step();
                end else begin
                    rx_bit_step(t.rx_line);
                end
            end else begin
                uart_tick = uart_tick + 8'd1;
            end
        end
        r.tx_line       = uart_line;
        r.tx_done       = uart_tx_fin;
        r.rx_done       = uart_rx_fin;
        r.rx_data       = uart_rx_shift;
        r.timer_running = uart_run;
    endtask

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= MAX_PRINTS) begin
            $display("ERROR: %s", msg);
        end
    endtask

    always @(posedge i_clk) begin
        tdu_pkg::t_result want;
        tick_taken <= in_if.valid && in_if.ready;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                uart_reload = cfg_if.data;
                n_reload_writes++;
            end
            if (out_if.valid && out_if.ready) begin
                if (expected_pins.size() == 0) begin
                    report_mismatch("result with no tick pending");
                end else begin
                    want = expected_pins.pop_front();
                    if (out_if.tx_line !== want.tx_line) begin
                        report_mismatch($sformatf("result %0d tx_line %b, expected %b",
                            n_checked, out_if.tx_line, want.tx_line));
                    end
                    if (out_if.tx_done !== want.tx_done) begin
                        report_mismatch($sformatf("result %0d tx_done %b, expected %b",
                            n_checked, out_if.tx_done, want.tx_done));
                    end
                    if (out_if.rx_done !== want.rx_done) begin
                        report_mismatch($sformatf("result %0d rx_done %b, expected %b",
                            n_checked, out_if.rx_done, want.rx_done));
                    end
                    if (out_if.rx_data !== want.rx_data) begin
                        report_mismatch($sformatf("result %0d rx_data %h, expected %h",
                            n_checked, out_if.rx_data, want.rx_data));
                    end
                    if (out_if.timer_running !== want.timer_running) begin
                        report_mismatch($sformatf("result %0d timer_running %b, expected %b",
                            n_checked, out_if.timer_running, want.timer_running));
                    end
                    n_checked++;
                end
            end
            if (in_if.valid && in_if.ready) begin
                uart_advance('{mode: in_if.mode, tx_data: in_if.tx_data, rx_line: in_if.rx_line},
                             want);
                expected_pins.push_back(want);
                n_taken++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_count = 0;
        end else begin
            idle_count++;
            if (idle_count >= IDLE_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("tb_timer_driven_uart_txrx NOT OK");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        logic offer;
        offer = 1'b0;
        if (i_rst_n) begin
            if (in_if.valid && !tick_taken) begin
                offer = 1'b1;
            end else if (send_gap > 0) begin
                send_gap--;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                send_gap = $urandom_range(0, 4);
            end else if (tick_queue.size() > 0) begin
                cur_tick = tick_queue.pop_front();
                offer    = 1'b1;
            end
        end
        in_if.valid   <= offer;
        in_if.mode    <= cur_tick.mode;
        in_if.tx_data <= cur_tick.tx_data;
        in_if.rx_line <= cur_tick.rx_line;
    end

    always @(negedge i_clk) begin
        logic take;
        take = 1'b1;
        if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            take      = 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            take = 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 4);
            take     = 1'b0;
        end
        out_if.ready <= take;
    end

    function automatic logic [1:0] plain_mode();
        return ($urandom_range(0, 19) == 0) ? MODE_SPARE : tdu_pkg::MODE_TICK;
    endfunction

    task automatic push_tick(input logic [1:0] mode, input logic [7:0] data, input logic rx);
        tick_queue.push_back('{mode: mode, tx_data: data, rx_line: rx});
        n_queued++;
    endtask

    task automatic queue_tx_frame(input int cut, input logic [7:0] data);
        int span;
        int t;
        span = FRAME_BITS * period + $urandom_range(0, 3);
        if (cut > 0 && cut < span) begin
            span = cut;
        end
        push_tick(tdu_pkg::MODE_TX, data, 1'($urandom));
        for (t = 1; t <= span; t++) begin
            push_tick(plain_mode(), 8'($urandom), 1'($urandom));
        end
        n_frames++;
    endtask

    task automatic queue_rx_frame(input int cut, input logic start_bit, input logic stop_bit,
                                  input logic [7:0] data);
        logic [FRAME_BITS-1:0] bits;
        logic lvl;
        int half;
        int lead;
        int span;
        int k;
        int t;
        bits = {stop_bit, data, start_bit};
        half = period >> 1;
        lead = (half == 0) ? 256 : half;
        span = lead + (FRAME_BITS - 1) * period + $urandom_range(0, 3);
        if (cut > 0 && cut < span) begin
            span = cut;
        end
        push_tick(tdu_pkg::MODE_RX, 8'($urandom), 1'($urandom));
        for (t = 1; t <= span; t++) begin
            k   = (t <= lead) ? 0 : (t - lead + period - 1) / period;
            lvl = (k < FRAME_BITS) ? bits[k] : 1'b1;
            if ($urandom_range(0, 39) == 0) begin
                lvl = ~lvl;
            end
            push_tick(plain_mode(), 8'($urandom), lvl);
        end
        n_frames++;
    endtask

    task automatic queue_noise(input int count);
        int pick;
        int t;
        logic [1:0] m;
        for (t = 0; t < count; t++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                m = tdu_pkg::MODE_TICK;
            end else if (pick == 6) begin
                m = tdu_pkg::MODE_TX;
            end else if (pick == 7) begin
                m = tdu_pkg::MODE_RX;
            end else begin
                m = MODE_SPARE;
            end
            push_tick(m, 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic queue_traffic(input int budget);
        int base;
        int pick;
        base = n_queued;
        while (n_queued - base < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
                queue_tx_frame(0, 8'($urandom));
            end else if (pick < 76) begin
                queue_rx_frame(0, $urandom_range(0, 9) == 0, $urandom_range(0, 6) != 0,
                               8'($urandom));
            end else if (pick < 82) begin
                queue_tx_frame($urandom_range(1, FRAME_BITS * period), 8'($urandom));
            end else if (pick < 88) begin
                queue_rx_frame($urandom_range(1, FRAME_BITS * period), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), 8'($urandom));
            end else begin
                queue_noise($urandom_range(5, 30));
            end
        end
    endtask

    task automatic drain();
        while (n_taken != n_queued || expected_pins.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reload(input logic [7:0] value);
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.data  = value;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
        period = 256 - int'(value);
    endtask

    initial begin
        int ph;
        in_if.valid   = 1'b0;
        in_if.mode    = tdu_pkg::MODE_TICK;
        in_if.tx_data = 8'd0;
        in_if.rx_line = 1'b1;
        out_if.ready  = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.data   = 8'd0;
        cur_tick      = '{mode: tdu_pkg::MODE_TICK, tx_data: 8'd0, rx_line: 1'b1};
        uart_reset();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        push_tick(tdu_pkg::MODE_TICK, 8'h00, 1'b0);
        push_tick(tdu_pkg::MODE_TICK, 8'hFF, 1'b1);
        push_tick(MODE_SPARE, 8'h5A, 1'b0);
        push_tick(tdu_pkg::MODE_TX, 8'hFF, 1'b1);
        push_tick(tdu_pkg::MODE_TICK, 8'h00, 1'b0);
        push_tick(MODE_SPARE, 8'hFF, 1'b1);
        push_tick(tdu_pkg::MODE_TICK, 8'h00, 1'b1);
        push_tick(tdu_pkg::MODE_TX, 8'h00, 1'b0);
        push_tick(tdu_pkg::MODE_TICK, 8'hAA, 1'b0);
        push_tick(tdu_pkg::MODE_RX, 8'h55, 1'b0);
        push_tick(tdu_pkg::MODE_TICK, 8'h00, 1'b0);
        push_tick(tdu_pkg::MODE_TICK, 8'hFF, 1'b0);
        push_tick(tdu_pkg::MODE_RX, 8'hFF, 1'b1);
        push_tick(MODE_SPARE, 8'h00, 1'b1);
        push_tick(tdu_pkg::MODE_TX, 8'h81, 1'b0);
        push_tick(tdu_pkg::MODE_RX, 8'h7E, 1'b1);
        push_tick(tdu_pkg::MODE_TICK, 8'h01, 1'b1);
        push_tick(tdu_pkg::MODE_TICK, 8'h80, 1'b0);
        drain();

        write_reload(8'hFF);
        queue_tx_frame(0, 8'hA5);
        queue_rx_frame(0, 1'b0, 1'b1, 8'h3C);
        queue_rx_frame(0, 1'b1, 1'b1, 8'h00);
        queue_rx_frame(0, 1'b0, 1'b0, 8'hFF);
        drain();

        write_reload(8'h00);
        push_tick(tdu_pkg::MODE_TX, 8'hC3, 1'b1);
        queue_noise(0);
        repeat (300) push_tick(tdu_pkg::MODE_TICK, 8'($urandom), 1'($urandom));
        push_tick(tdu_pkg::MODE_RX, 8'h00, 1'b0);
        repeat (150) push_tick(tdu_pkg::MODE_TICK, 8'($urandom), 1'b0);
        drain();

        for (ph = 0; ph < 6; ph++) begin
            write_reload(8'($urandom_range(244, 255)));
            queue_traffic(PHASE_ITEMS);
            if (ph == 2) begin
                hold_req = 1'b1;
            end
            drain();
        end

        quiet = 1'b1;
        write_reload(8'd250);
        queue_traffic(150);
        drain();
        repeat (4) @(posedge i_clk);

        if (expected_pins.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_pins.size()));
        end
        $display("run: %0d ticks sent, %0d results checked, %0d frames", n_queued, n_checked,
                 n_frames);
        $display("run: %0d reload writes, long output stall %s, %0d mismatches", n_reload_writes,
                 hold_done ? "done" : "missed", n_errors);
        if (n_errors == 0) begin
            $display("tb_timer_driven_uart_txrx OK");
        end else begin
            $display("tb_timer_driven_uart_txrx NOT OK");
        end
        $finish;
    end

endmodule
